[hdl/hcbd_pkg.sv]
`default_nettype none

package hcbd_pkg;

  localparam int CountBits = 32;

  typedef enum logic [5:0] {
    PH_SIZE   = 6'b000001,
    PH_SKIP   = 6'b000010,
    PH_DATA   = 6'b000100,
    PH_TRAIL1 = 6'b001000,
    PH_TRAIL2 = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.hit   = 1'b1;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = 4'(b - 8'h37);
    end else begin
      h.hit = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

[hdl/hcbd_parse.sv]
`default_nettype none

module hcbd_parse
  import hcbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  input  wire logic       new_body,
  output      logic       push,
  output      result_t    result
);

  phase_t               phase, phase_cur, phase_next;
  logic [CountBits-1:0] byte_count, count_cur, byte_count_next;
  logic                 digit_seen, seen_cur, digit_seen_next;
  hex_t                 hex;
  logic [CountBits-1:0] count_dec;

  always_comb begin
    phase_cur       = new_body ? PH_SIZE : phase;
    count_cur       = new_body ? '0 : byte_count;
    seen_cur        = new_body ? 1'b0 : digit_seen;
    hex             = hex_decode(in_byte);
    count_dec       = count_cur - CountBits'(1);
    phase_next      = phase_cur;
    byte_count_next = count_cur;
    digit_seen_next = seen_cur;
    push            = 1'b0;
    result.data     = in_byte;
    result.last     = 1'b0;
    case (phase_cur)
      PH_SIZE: begin
        if (hex.hit) begin
          if (count_cur[CountBits-1 -: 4] != 4'd0) begin
            byte_count_next = '1;
          end else begin
            byte_count_next = {count_cur[CountBits-5:0], hex.value};
          end
          digit_seen_next = 1'b1;
        end else if (!seen_cur && (in_byte inside {8'd32, [8'd9:8'd13]})) begin
          phase_next = PH_SIZE;
        end else if (count_cur == '0) begin
          phase_next      = PH_DONE;
          digit_seen_next = 1'b0;
          push            = 1'b1;
          result.data     = 8'd0;
          result.last     = 1'b1;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP: phase_next = PH_DATA;
      PH_DATA: begin
        push            = 1'b1;
        byte_count_next = count_dec;
        if (count_dec == '0) begin
          phase_next = PH_TRAIL1;
        end
      end
      PH_TRAIL1: phase_next = PH_TRAIL2;
      PH_TRAIL2: begin
        phase_next      = PH_SIZE;
        byte_count_next = '0;
        digit_seen_next = 1'b0;
      end
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_SIZE;
    endcase
    push = push && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SIZE;
      byte_count <= '0;
      digit_seen <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      digit_seen <= digit_seen_next;
    end
  end

endmodule

`default_nettype wire

[hdl/hcbd_out.sv]
`default_nettype none

module hcbd_out
  import hcbd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output      logic    room,
  output      logic    out_valid,
  input  wire logic    out_ready,
  output      result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    slot_free;

  assign slot_free = !out_valid || out_ready;
  assign room      = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

[hdl/http_chunked_body_decoder_top.sv]
// Chunked body decoder: strips the hex size lines and trailers of an HTTP
// chunked body and passes only the payload bytes.
// Input channel: in_valid/in_ready request carrying in_byte and new_body.
// Set new_body on the first byte of a body to restart the parser.
// Output channel: out_valid/out_ready request carrying out_byte and body_end.
// A payload byte has body_end low; the end of a body gives one request
// with body_end high and out_byte zero, after which bytes are dropped
// until the next new_body.
// Throughput: one input byte per cycle while in_ready is high, set by the
// parser state update on each accepted byte. A result formed from an
// accepted byte is registered in the output stage before it is offered.
// When the receiver stalls, one more result is held in a skid register;
// in_ready drops only while that register is full.
// Reset (rst, synchronous) returns the parser to reading a chunk size and
// empties the output stage.
`default_nettype none

module http_chunked_body_decoder_top
  import hcbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       new_body,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [7:0] out_byte,
  output      logic       body_end
);

  logic    accept;
  logic    push;
  result_t result;
  result_t out_data;

  assign accept = in_valid && in_ready;

  hcbd_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_byte    (in_byte),
    .new_body   (new_body),
    .push       (push),
    .result     (result)
  );

  hcbd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_byte = out_data.data;
  assign body_end = out_data.last;

endmodule

`default_nettype wire
